/* design/tkst_pkg.sv */
`timescale 1ns / 1ps

package tkst_pkg;

    localparam int OP_W    = 2;
    localparam int SCORE_W = 32;
    localparam int USER_W  = 16;
    localparam int POS_W   = 4;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 4;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_RENAME = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LAST,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [RANK_W-1:0]         rank;
        logic                      success;
        logic [USER_W-1:0]         entry_user;
        logic signed [SCORE_W-1:0] entry_score;
        logic [COUNT_W-1:0]        entry_count;
    } t_result;

endpackage

/* design/top_k_score_table.sv */
`timescale 1ns / 1ps
// an insert walks downward over the table memories from the tail, one slot a cycle,
// to the slot where the new entry goes; rename and read act on the slot the position
// names, and every operation ends with a result word on the master side
// throughput: one operation at a time, the next word is taken once the result
// has moved into the output register
// reset: sync active low, clears state, entry count and output valid; memories not cleared

module top_k_score_table #(
    parameter int TABLE_ENTRIES = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // score[31:0], user_id[47:32], position[51:48], zero pad
    input  logic [tkst_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation[1:0]
    input  logic [tkst_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // rank[3:0], success[4], entry_user[20:5], entry_score[52:21],
    // entry_count[56:53], zero pad
    output logic [tkst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import tkst_pkg::*;

    t_result res;
    logic    res_valid, res_ready;

    tkst_seq #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_score     (signed'(s_axis_tdata[SCORE_W-1:0])),
        .i_user      (s_axis_tdata[SCORE_W +: USER_W]),
        .i_pos       (s_axis_tdata[SCORE_W+USER_W +: POS_W]),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready)
    );

    tkst_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res         (res),
        .i_res_valid   (res_valid),
        .o_res_ready   (res_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* design/tkst_ram.sv */
`timescale 1ns / 1ps

module tkst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/tkst_seq.sv */
`timescale 1ns / 1ps

module tkst_seq #(
    parameter int TABLE_ENTRIES = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [tkst_pkg::OP_W-1:0]            i_op,
    input  logic signed [tkst_pkg::SCORE_W-1:0]  i_score,
    input  logic [tkst_pkg::USER_W-1:0]          i_user,
    input  logic [tkst_pkg::POS_W-1:0]           i_pos,
    output tkst_pkg::t_result                    o_res,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready
);

    import tkst_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [SCORE_W-1:0] r_score, n_score;
    logic [USER_W-1:0]         r_user, n_user;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_skip, n_skip;
    logic                      r_first, n_first;
    logic signed [SCORE_W-1:0] r_min, n_min;
    t_result                   r_res, n_res;

    logic                      sc_wr_en, us_wr_en, rd_en;
    logic [IDX_W-1:0]          wr_addr, rd_addr;
    logic [SCORE_W-1:0]        wr_score, rd_score_raw;
    logic [USER_W-1:0]         wr_user, rd_user;
    logic signed [SCORE_W-1:0] rd_score;

    logic                      accept, pos_ok, full;
    logic [IDX_W-1:0]          pos_idx, idx_up;
    logic [POS_W-1:0]          pos_m1;

    tkst_ram #(.WIDTH(SCORE_W), .DEPTH(TABLE_ENTRIES)) u_score_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sc_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_score),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_score_raw)
    );

    tkst_ram #(.WIDTH(USER_W), .DEPTH(TABLE_ENTRIES)) u_user_ram (
        .i_clk     (i_clk),
        .i_wr_en   (us_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_user),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_user)
    );

    assign rd_score = signed'(rd_score_raw);
    assign accept   = i_in_valid && o_in_ready;
    assign full     = (r_count == CNT_W'(TABLE_ENTRIES));
    assign pos_m1   = i_pos - POS_W'(1);
    assign pos_idx  = IDX_W'(pos_m1);
    assign pos_ok   = (i_pos != '0) && (CMP_W'(i_pos) <= CMP_W'(r_count));
    assign idx_up   = r_idx + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
        r_user  <= n_user;
        r_idx   <= n_idx;
        r_skip  <= n_skip;
        r_first <= n_first;
        r_min   <= n_min;
        r_res   <= n_res;
    end

    // insertion walks downward from the tail: each word read moves one slot
    // back, is skipped as a minimum, or marks where the new entry goes. reads
    // and writes in one cycle always hit different slots; no forwarding needed
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_score  = r_score;
        n_user   = r_user;
        n_idx    = r_idx;
        n_skip   = r_skip;
        n_first  = r_first;
        n_min    = r_min;
        n_res    = r_res;
        sc_wr_en = 1'b0;
        us_wr_en = 1'b0;
        wr_addr  = '0;
        wr_score = r_score;
        wr_user  = r_user;
        rd_en    = 1'b0;
        rd_addr  = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_score = i_score;
                    n_user  = i_user;
                    n_res   = '0;
                    n_state = ST_EMIT;
                    unique case (i_op)
                        OP_INSERT: begin
                            if (r_count == '0) begin
                                sc_wr_en = 1'b1;
                                us_wr_en = 1'b1;
                                wr_score = i_score;
                                wr_user  = i_user;
                                n_count  = CNT_W'(1);
                                n_res.rank    = RANK_W'(1);
                                n_res.success = 1'b1;
                            end else if (!full) begin
                                // room left: the insert always lands
                                n_count = r_count + CNT_W'(1);
                                n_idx   = IDX_W'(r_count - CNT_W'(1));
                                rd_en   = 1'b1;
                                rd_addr = n_idx;
                                n_skip  = 1'b0;
                                n_first = 1'b0;
                                n_state = ST_WALK;
                            end else begin
                                n_idx   = IDX_W'(TABLE_ENTRIES - 1);
                                rd_en   = 1'b1;
                                rd_addr = n_idx;
                                n_skip  = 1'b1;
                                n_first = 1'b1;
                                n_state = ST_WALK;
                            end
                        end
                        OP_RENAME: begin
                            if (pos_ok) begin
                                us_wr_en = 1'b1;
                                wr_addr  = pos_idx;
                                wr_user  = i_user;
                                n_res.success = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (pos_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = pos_idx;
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (r_first) begin
                    // tail word of a full table is the minimum
                    n_first = 1'b0;
                    n_min   = rd_score;
                    if (r_score > rd_score) begin
                        n_idx   = r_idx - IDX_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = n_idx;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else if (r_skip && (rd_score == r_min)) begin
                    // newer minimum entries stay put, the oldest one goes
                    if (r_idx == '0) begin
                        sc_wr_en = 1'b1;
                        us_wr_en = 1'b1;
                        wr_addr  = '0;
                        n_res.rank    = RANK_W'(1);
                        n_res.success = 1'b1;
                        n_state  = ST_EMIT;
                    end else begin
                        n_idx   = r_idx - IDX_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = n_idx;
                    end
                end else begin
                    n_skip = 1'b0;
                    if (rd_score < r_score) begin
                        sc_wr_en = 1'b1;
                        us_wr_en = 1'b1;
                        wr_addr  = idx_up;
                        wr_score = rd_score_raw;
                        wr_user  = rd_user;
                        if (r_idx == '0) begin
                            n_state = ST_LAST;
                        end else begin
                            n_idx   = r_idx - IDX_W'(1);
                            rd_en   = 1'b1;
                            rd_addr = n_idx;
                        end
                    end else begin
                        sc_wr_en = 1'b1;
                        us_wr_en = 1'b1;
                        wr_addr  = idx_up;
                        n_res.rank    = RANK_W'(idx_up) + RANK_W'(1);
                        n_res.success = 1'b1;
                        n_state  = ST_EMIT;
                    end
                end
            end
            ST_LAST: begin
                sc_wr_en = 1'b1;
                us_wr_en = 1'b1;
                wr_addr  = '0;
                n_res.rank    = RANK_W'(1);
                n_res.success = 1'b1;
                n_state  = ST_EMIT;
            end
            ST_READ: begin
                n_res.entry_user  = rd_user;
                n_res.entry_score = rd_score;
                n_res.success     = 1'b1;
                n_state           = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_EMIT);

    always_comb begin
        o_res = r_res;
        o_res.entry_count = COUNT_W'(r_count);
    end

endmodule

/* design/tkst_out.sv */
`timescale 1ns / 1ps

module tkst_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tkst_pkg::t_result                   i_res,
    input  logic                                i_res_valid,
    output logic                                o_res_ready,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tkst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import tkst_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - (RANK_W + 1 + USER_W + SCORE_W + COUNT_W);

    logic    r_valid, n_valid;
    t_result r_res, n_res;

    assign o_res_ready = !r_valid || m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (o_res_ready) begin
            n_valid = i_res_valid;
            if (i_res_valid) begin
                n_res = i_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {PAD_W'(0), r_res.entry_count, r_res.entry_score,
                            r_res.entry_user, r_res.success, r_res.rank};

endmodule

/* design/tkst_chk.sv */
`timescale 1ns / 1ps

module tkst_chk #(
    parameter int TABLE_ENTRIES = 10
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tkst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one operation at a time: ready drops after every accepted word
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word accepted while an operation was in flight");

    // a nonzero rank only comes with a successful insert
    a_rank_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:0] != 4'd0) |-> m_axis_tdata[4])
        else $error("rank given without success");

    // entry data is only returned by a valid read
    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tdata[20:5] != 16'd0) || (m_axis_tdata[52:21] != 32'd0))
        |-> m_axis_tdata[4])
        else $error("entry data without success");

    // the inserted entry never ranks below the entry count
    a_rank_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (TABLE_ENTRIES < 16) && m_axis_tvalid && (m_axis_tdata[3:0] != 4'd0)
        |-> (m_axis_tdata[3:0] <= m_axis_tdata[56:53]))
        else $error("rank beyond entry count");

endmodule

bind top_k_score_table tkst_chk #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_chk (.*);
